>>> src/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg: shared types and constants of the current moving average block
// Transaction payload types, constant widths and the fixed-point constants
// used for scaling and rounding to amperes.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

   // field widths fixed by the interface
   localparam int SAMPLE_W  = 10;
   localparam int GAIN_W    = 16;
   localparam int SCALED_W  = 26;
   localparam int AMPERES_W = 17;
   localparam int USED_W    = 7;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_GAIN = 1'b0;   // register index, taken from paddr[2]

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1000;
   localparam int DEFAULT_WINDOW = 100;

   // operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // rounding to amperes: (x + 500) / 1000 as (x + 500) * RECIP >> RECIP_SHIFT,
   // exact for any 26-bit x since 1000 * RECIP - 2^36 = 264 < 2^10
   localparam logic [SCALED_W-1:0] ROUND_HALF = 26'd500;
   localparam int RECIP_SHIFT = 36;
   localparam int RECIP_W     = 27;
   localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
   localparam int PROD_W = SCALED_W + RECIP_W;

   typedef struct packed {
      logic                opcode;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SCALED_W-1:0]  scaled_average;
      logic [AMPERES_W-1:0] amperes;
      logic [USED_W-1:0]    samples_used;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/current_moving_average.sv
// ----------------------------------------------------------------------------
// current_moving_average: moving average of current-sensor samples
// Growing-window average over the last WINDOW samples, scaled by a gain and
// rounded to amperes.
// ----------------------------------------------------------------------------
// One sample transaction is handled at a time. From acceptance to the result
// being offered it updates the running sum and the sample memory, loads the
// divider, divides in the restoring divider (sum / fill count) with one step
// per bit of the running sum, then does the gain multiply, the rounding to
// amperes and the output register. A clear transaction gives no result. A new
// transaction is accepted while the previous result still waits in the output
// register. The sample memory is not initialised; an entry is only read for
// subtraction once written. Register 0 (byte address 0) holds the 16-bit gain,
// reset 1000.
`default_nettype none

module current_moving_average #(
   parameter int WINDOW = cma_pkg::DEFAULT_WINDOW
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // sample transactions
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  cma_pkg::req_type               req_data,
   // results
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output cma_pkg::rsp_type                     rsp_data,
   // register port
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [cma_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire  [cma_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [cma_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = cma_pkg::SAMPLE_W + CNT_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UPD  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_RND  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [cma_pkg::GAIN_W-1:0]     gain_ff, gain_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [IDX_W-1:0]               pos_ff, pos_in;
   logic [CNT_W-1:0]               fill_ff, fill_in;
   logic [cma_pkg::SAMPLE_W-1:0]   smp_ff, smp_in;
   logic                           start_ff, start_in;
   logic [cma_pkg::SCALED_W-1:0]   scaled_ff, scaled_in;
   logic [cma_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   cma_pkg::rsp_type               rsp_data_ff, rsp_data_in;
   logic [cma_pkg::SAMPLE_W-1:0]   rd_data_ff;
   logic [cma_pkg::SAMPLE_W-1:0]   store_mem [WINDOW];

   logic                           req_fire;
   logic                           csr_write;
   logic                           store_wr;
   logic                           store_full;
   logic                           out_free;
   logic                           div_done;
   logic [SUM_W-1:0]               div_quo;
   logic [cma_pkg::SCALED_W-1:0]   rnd_sum;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      gain_in = gain_ff;
      if (csr_write && csr_paddr[2] == cma_pkg::REG_GAIN) begin
         gain_in = csr_pwdata[cma_pkg::GAIN_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == cma_pkg::REG_GAIN) begin
         csr_prdata = cma_pkg::CSR_DATA_W'(gain_ff);
      end
   end

   // sample memory: registered read at the write position, written on update
   assign store_wr = (state_ff == S_UPD);

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_mem[pos_ff] <= smp_ff;
      end
      rd_data_ff <= store_mem[pos_ff];
   end

   // divider: running sum over fill count
   cma_div #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (sum_ff),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign store_full = (fill_ff == CNT_W'(WINDOW));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rnd_sum    = scaled_ff + cma_pkg::ROUND_HALF;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      smp_in       = smp_ff;
      start_in     = 1'b0;
      scaled_in    = scaled_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.opcode == cma_pkg::OP_CLEAR) begin
                  sum_in  = '0;
                  pos_in  = '0;
                  fill_in = '0;
               end else begin
                  smp_in   = req_data.sample;
                  state_in = S_UPD;
               end
            end
         end
         S_UPD: begin
            // drop the oldest sample once the window is full
            sum_in = sum_ff - (store_full ? SUM_W'(rd_data_ff) : '0) + SUM_W'(smp_ff);
            if (pos_ff == IDX_W'(WINDOW - 1)) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + IDX_W'(1);
            end
            if (!store_full) begin
               fill_in = fill_ff + CNT_W'(1);
            end
            start_in = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               scaled_in = cma_pkg::SCALED_W'(div_quo[cma_pkg::SAMPLE_W-1:0])
                         * cma_pkg::SCALED_W'(gain_ff);
               state_in  = S_RND;
            end
         end
         S_RND: begin
            prod_in  = cma_pkg::PROD_W'(rnd_sum) * cma_pkg::PROD_W'(cma_pkg::RECIP);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.scaled_average  = scaled_ff;
               rsp_data_in.amperes         = prod_ff[cma_pkg::PROD_W-1:cma_pkg::RECIP_SHIFT];
               rsp_data_in.samples_used    = cma_pkg::USED_W'(fill_ff);
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gain_ff      <= cma_pkg::GAIN_RESET;
         sum_ff       <= '0;
         pos_ff       <= '0;
         fill_ff      <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      smp_ff      <= smp_in;
      scaled_ff   <= scaled_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(WINDOW))
      else $error("fill count above window");

   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.opcode == cma_pkg::OP_CLEAR
      |=> fill_ff == '0 && sum_ff == '0 && pos_ff == '0)
      else $error("clear did not restart the averaging");

   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> (fill_ff != '0) && (sum_ff <= SUM_W'(fill_ff) * SUM_W'(1023)))
      else $error("running sum out of range for fill count");

endmodule

`default_nettype wire

>>> src/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div: restoring divider, one quotient bit per cycle
// Divides the running sum by the fill count. Start loads the operands, done
// pulses for one cycle once the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_div #(
   parameter int DIVIDEND_W = 17,
   parameter int DIVISOR_W  = 7
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire  [DIVIDEND_W-1:0]  dividend,
   input  wire  [DIVISOR_W-1:0]   divisor,
   output logic                   done,
   output logic [DIVIDEND_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  bit_ok;

   // one shift-subtract step
   assign trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff   = trial - {1'b0, dvs_ff};
   assign bit_ok = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = bit_ok ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], bit_ok};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the current moving average block
// A short table of directed transactions (extremes, clears, rounding edges,
// gain limits) followed by random phases at several gain settings. Every
// accepted sample updates a local model of the averaging window, which gives
// the expected result unless the table row states it, and each result is
// compared field by field in arrival order. Both sides of the stream stall at
// random; the gain register is written and read back between phases, once the
// block has gone idle.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW       = cma_pkg::DEFAULT_WINDOW;
   localparam int HALF_PERIOD  = 4;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASES       = 6;

   localparam int PHASE_GAIN  [PHASES] = '{1000, 65535, -1, 1, 0, -1};
   localparam int PHASE_ITEMS [PHASES] = '{100, 100, 100, 100, 50, 100};

   localparam logic [cma_pkg::CSR_ADDR_W-1:0] GAIN_ADDR  = {cma_pkg::REG_GAIN, 2'b00};
   localparam logic [cma_pkg::CSR_ADDR_W-1:0] SPARE_ADDR = {~cma_pkg::REG_GAIN, 2'b00};

   typedef enum logic [1:0] {ROW_ITEM, ROW_GAIN} row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      cma_pkg::req_type             req;
      logic [cma_pkg::GAIN_W-1:0]   gain_value;
      logic                         typed;
      cma_pkg::rsp_type             want;
   } stim_row_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   cma_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   cma_pkg::rsp_type               rsp_data;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [cma_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [cma_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [cma_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // local copy of the averaging state
   logic [cma_pkg::SAMPLE_W-1:0]   hist [WINDOW];
   int unsigned                    hist_sum;
   int                             next_slot;
   int                             held_count;
   logic [cma_pkg::GAIN_W-1:0]     gain_setting;

   cma_pkg::rsp_type               pending_avgs [$];
   stim_row_type                   stim_rows [$];
   int                             errors = 0;
   int                             rd_errors;
   int                             cycle_count = 0;
   int                             stall_left = 0;
   int                             ready_roll;
   bit                             calm;
   cma_pkg::rsp_type               got_want;

   current_moving_average dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stalls, mostly short, except in calm phases
   always @(posedge clock) begin
      if (calm) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         ready_roll = $urandom_range(0, 99);
         if (ready_roll < 75) begin
            rsp_ready <= 1'b1;
         end else if (ready_roll < 95) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            stall_left = $urandom_range(15, 60);
            rsp_ready <= 1'b0;
         end
      end
   end

   // result checker: each transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_avgs.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %0d/%0d/%0d", $time,
                     rsp_data.scaled_average, rsp_data.amperes, rsp_data.samples_used);
            errors++;
         end else begin
            got_want = pending_avgs.pop_front();
            if (rsp_data.scaled_average !== got_want.scaled_average) begin
               $display("%0t: scaled_average expected %0d, got %0d", $time,
                        got_want.scaled_average, rsp_data.scaled_average);
               errors++;
            end
            if (rsp_data.amperes !== got_want.amperes) begin
               $display("%0t: amperes expected %0d, got %0d", $time,
                        got_want.amperes, rsp_data.amperes);
               errors++;
            end
            if (rsp_data.samples_used !== got_want.samples_used) begin
               $display("%0t: samples_used expected %0d, got %0d", $time,
                        got_want.samples_used, rsp_data.samples_used);
               errors++;
            end
         end
      end
   end

   // window update and scaling for one transaction; clear gives no result
   function automatic bit average_next(cma_pkg::req_type r, output cma_pkg::rsp_type res);
      longint unsigned avg;
      longint unsigned scaled;
      longint unsigned amps;
      res = '0;
      if (r.opcode == cma_pkg::OP_CLEAR) begin
         hist_sum   = 0;
         next_slot  = 0;
         held_count = 0;
         return 1'b0;
      end
      // oldest sample leaves only once the window is full
      if (held_count >= WINDOW)
         hist_sum -= hist[next_slot];
      hist_sum += r.sample;
      hist[next_slot] = r.sample;
      next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
      if (held_count < WINDOW)
         held_count++;
      avg    = hist_sum / held_count;
      scaled = avg * gain_setting;
      amps   = (scaled + 500) / 1000;
      res.scaled_average = cma_pkg::SCALED_W'(scaled);
      res.amperes        = cma_pkg::AMPERES_W'(amps);
      res.samples_used   = cma_pkg::USED_W'(held_count);
      return 1'b1;
   endfunction

   // offer one transaction and hold it until accepted
   task automatic send_item(cma_pkg::req_type r, bit typed, cma_pkg::rsp_type want);
      cma_pkg::rsp_type res;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (average_next(r, res))
         pending_avgs.push_back(typed ? want : res);
   endtask

   function automatic int pick_gap();
      int roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 60);
   endfunction

   task automatic idle_after(int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending and let every outstanding result drain
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [cma_pkg::CSR_ADDR_W-1:0] addr,
                            logic [cma_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == GAIN_ADDR)
         gain_setting = value[cma_pkg::GAIN_W-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_gain();
      logic [cma_pkg::CSR_DATA_W-1:0] want_rd;
      want_rd = cma_pkg::CSR_DATA_W'(gain_setting);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= GAIN_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want_rd) begin
         $display("%0t: gain readback expected %0d, got %0d", $time, want_rd, csr_prdata);
         rd_errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_row(row_kind_type k, logic op, int smp, int gv,
                                   bit typed, int sc, int am, int used);
      stim_row_type row;
      row.kind                = k;
      row.req.opcode          = op;
      row.req.sample          = cma_pkg::SAMPLE_W'(smp);
      row.gain_value          = cma_pkg::GAIN_W'(gv);
      row.typed               = typed;
      row.want.scaled_average = cma_pkg::SCALED_W'(sc);
      row.want.amperes        = cma_pkg::AMPERES_W'(am);
      row.want.samples_used   = cma_pkg::USED_W'(used);
      stim_rows.push_back(row);
   endfunction

   function automatic cma_pkg::req_type random_req();
      cma_pkg::req_type r;
      r.sample = cma_pkg::SAMPLE_W'($urandom);
      r.opcode = ($urandom_range(0, 119) == 0) ? cma_pkg::OP_CLEAR : cma_pkg::OP_SAMPLE;
      case ($urandom_range(0, 9))
         0: r.sample = '0;
         1: r.sample = '1;
         default: ;
      endcase
      return r;
   endfunction

   // main sequence
   initial begin
      cma_pkg::rsp_type none;
      int gv;

      none        = '0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      rd_errors   = 0;
      calm        = 1'b0;
      hist_sum    = 0;
      next_slot   = 0;
      held_count  = 0;
      gain_setting = cma_pkg::GAIN_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: reset gain, extremes, clears, rounding edge
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 1023, 0, 1, 1023000, 1023, 1);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 0,    0, 1, 511000,  511,  2);
      add_row(ROW_ITEM, cma_pkg::OP_CLEAR,  1023, 0, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 0,    0, 1, 0, 0, 1);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 512,  0, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 1,    0, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_CLEAR,  0,    0, 0, 0, 0, 0);
      add_row(ROW_GAIN, cma_pkg::OP_SAMPLE, 0, 65535, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 1023, 0, 1, 67042305, 67042, 1);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 1023, 0, 1, 67042305, 67042, 2);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 341,  0, 0, 0, 0, 0);
      add_row(ROW_GAIN, cma_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 700,  0, 1, 0, 0, 4);
      add_row(ROW_GAIN, cma_pkg::OP_SAMPLE, 0, 1, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_CLEAR,  0,    0, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 500,  0, 1, 500, 1, 1);
      add_row(ROW_ITEM, cma_pkg::OP_CLEAR,  0,    0, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 499,  0, 1, 499, 0, 1);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 2,    0, 0, 0, 0, 0);
      add_row(ROW_GAIN, cma_pkg::OP_SAMPLE, 0, 1000, 0, 0, 0, 0);
      add_row(ROW_ITEM, cma_pkg::OP_SAMPLE, 777,  0, 0, 0, 0, 0);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_GAIN) begin
            settle();
            csr_write(GAIN_ADDR, cma_pkg::CSR_DATA_W'(stim_rows[i].gain_value));
         end else begin
            send_item(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
            idle_after(pick_gap());
         end
      end

      // random phases, one gain setting each; phase two runs without idling
      for (int p = 0; p < PHASES; p++) begin
         settle();
         gv = (PHASE_GAIN[p] < 0) ? $urandom_range(0, 65535) : PHASE_GAIN[p];
         csr_write(GAIN_ADDR, {16'($urandom), 16'(gv)});
         csr_write(SPARE_ADDR, $urandom);
         csr_check_gain();
         calm = (p == 2);
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            send_item(random_req(), 1'b0, none);
            idle_after(pick_gap());
            // hold off once until the pipeline has fully drained
            if (p == 1 && n == 60) begin
               req_valid <= 1'b0;
               while (pending_avgs.size() != 0) @(posedge clock);
            end
         end
      end

      calm = 1'b0;
      settle();
      if (errors == 0 && rd_errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> current_moving_average.f
src/cma_pkg.sv
src/cma_div.sv
src/current_moving_average.sv
bench/tb_top.sv
